FILE: sv/assert_macros.svh
// Assertion macros shared by the string escape decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, outside reset.
`define SED_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("string escape decoder assertion failed");

// Checks that a condition never holds, outside reset.
`define SED_ASSERT_NEVER(label, clk, rst, cond) \
   `SED_ASSERT(label, clk, rst, !(cond))

`endif

FILE: sv/sed_pkg.sv
// Package with the types and constants of the string escape decoder.
package sed_pkg;

   localparam int unsigned SED_QUEUE_DEPTH = 4;
   localparam int unsigned SED_MAX_BYTES   = 5;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] BYTE_TAB     = 8'h09;
   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_CR      = 8'h0D;

   // Decoded bytes caused by one request, oldest in entry zero.
   typedef struct packed {
      logic [SED_MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                    count;
   } sed_bundle_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } sed_queue_status_type;

endpackage

FILE: sv/string_escape_decoder.sv
// Top level of the string escape decoder: front, bundle queue and back.
//
// The req_ channel takes one raw character of a string literal per request,
// with req_text_end high on the final character. The rsp_ channel returns
// the decoded bytes, one per response, with rsp_run_end high on the last
// byte caused by a given request; a request may cause no byte at all (a
// backslash, for example), or up to five (a closed code point plus the
// character that closed it).
// A request is accepted at a clock edge where valid is high and stall low.
// The front decodes a character in the cycle it is accepted and writes the
// bytes it causes, as one bundle, into a queue of QUEUE_DEPTH bundles. The
// back sends one byte per cycle from the head bundle, while rsp_stall is
// low, through an output register, so the first byte of a request passes
// the queue and then the output register before it shows on rsp_. One
// character per cycle goes in as long as each causes at most one byte and
// rsp_stall stays low; req_stall rises only on a full queue.
// When rsp_stall is high the output register holds its byte, the back stops
// and the queue fills; the front keeps taking characters until then.
// Synchronous reset returns the decoder to plain text, empties the queue
// and drops any byte not yet taken.
module string_escape_decoder #(
   parameter int unsigned QUEUE_DEPTH = sed_pkg::SED_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_text_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end
);
   import sed_pkg::*;

   sed_queue_status_type queue_status;
   sed_bundle_type       push_bundle;
   sed_bundle_type       head_bundle;
   logic                 push;
   logic                 pop;

   // Escape state and byte bundle construction.
   sed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ch       (req_ch),
      .req_text_end (req_text_end),
      .queue_status (queue_status),
      .push         (push),
      .bundle       (push_bundle)
   );

   // The queue lets the front run ahead while long UTF-8 sequences drain.
   sed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head_bundle (head_bundle),
      .status      (queue_status)
   );

   // Byte serializer with the registered response stage.
   sed_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_bundle  (head_bundle),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end)
   );

endmodule

FILE: sv/sed_front.sv
// Front part: accepts characters, tracks the escape state and builds byte bundles.
`include "assert_macros.svh"

module sed_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_ch,
   input  logic                          req_text_end,
   input  sed_pkg::sed_queue_status_type queue_status,
   output logic                          push,
   output sed_pkg::sed_bundle_type       bundle
);
   import sed_pkg::*;

   typedef enum logic [4:0] {
      MODE_NORMAL = 5'b00001,
      MODE_ESC    = 5'b00010,
      MODE_HEX1   = 5'b00100,
      MODE_U      = 5'b01000,
      MODE_CP     = 5'b10000
   } sed_mode_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } sed_utf8_type;

   // Bit 4 flags a hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   function automatic sed_utf8_type utf8_encode(input logic [31:0] cp);
      sed_utf8_type u;
      u.bytes = '0;
      u.count = 3'd0;
      if (cp <= 32'h7F) begin
         u.bytes[0] = cp[7:0];
         u.count    = 3'd1;
      end else if (cp <= 32'h7FF) begin
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
         u.count    = 3'd2;
      end else if (cp <= 32'hFFFF) begin
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
         u.count    = 3'd3;
      end else if (cp <= 32'h10FFFF) begin
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
         u.count    = 3'd4;
      end
      return u;
   endfunction

   sed_mode_type mode_ff, mode_in;
   logic [7:0]   held_ff, held_in;
   logic [31:0]  cp_ff, cp_in;

   logic         accept;
   logic [4:0]   ch_hex;
   logic [4:0]   held_hex;
   logic [31:0]  cp_shift;
   logic         cp_closed;
   logic [31:0]  cp_sel;
   sed_utf8_type utf8;
   logic [2:0]   nb;
   logic [SED_MAX_BYTES-1:0][7:0] bytes;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;
   assign ch_hex    = hex_digit(req_ch);
   assign held_hex  = hex_digit(held_ff);
   assign cp_shift  = {cp_ff[27:0], ch_hex[3:0]};
   // A code point is sent either when a non-hex character closes it, or
   // when the text ends while it is open, after a hex digit or the brace.
   assign cp_closed = (mode_ff == MODE_CP) && !ch_hex[4];
   assign cp_sel    = cp_closed ? cp_ff : cp_shift;
   assign utf8      = utf8_encode(cp_sel);

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      cp_in   = cp_ff;
      bytes   = '0;
      nb      = 3'd0;
      unique case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_NORMAL;
            unique case (req_ch)
               CH_T:         begin bytes[0] = BYTE_TAB;     nb = 3'd1; end
               CH_N:         begin bytes[0] = BYTE_LF;      nb = 3'd1; end
               CH_R:         begin bytes[0] = BYTE_CR;      nb = 3'd1; end
               CH_DQUOTE:    begin bytes[0] = CH_DQUOTE;    nb = 3'd1; end
               CH_BACKSLASH: begin bytes[0] = CH_BACKSLASH; nb = 3'd1; end
               CH_SQUOTE:    begin bytes[0] = CH_SQUOTE;    nb = 3'd1; end
               CH_U:         mode_in = MODE_U;
               default: begin
                  if (ch_hex[4]) begin
                     held_in = req_ch;
                     mode_in = MODE_HEX1;
                  end else begin
                     bytes[0] = req_ch;
                     nb       = 3'd1;
                  end
               end
            endcase
         end
         MODE_HEX1: begin
            mode_in = MODE_NORMAL;
            if (ch_hex[4]) begin
               bytes[0] = {held_hex[3:0], ch_hex[3:0]};
               nb       = 3'd1;
            end else begin
               bytes[0] = held_ff;
               nb       = 3'd1;
               if (req_ch == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  bytes[1] = req_ch;
                  nb       = 3'd2;
               end
            end
         end
         MODE_U: begin
            mode_in = MODE_NORMAL;
            if (req_ch == CH_LBRACE) begin
               cp_in   = 32'd0;
               mode_in = MODE_CP;
            end else if (req_ch == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               bytes[0] = req_ch;
               nb       = 3'd1;
            end
         end
         MODE_CP: begin
            if (ch_hex[4]) begin
               cp_in = cp_shift;
            end else begin
               bytes[3:0] = utf8.bytes;
               nb         = utf8.count;
               cp_in      = 32'd0;
               mode_in    = MODE_NORMAL;
               if (req_ch == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else if (req_ch != CH_RBRACE) begin
                  bytes[nb] = req_ch;
                  nb        = nb + 3'd1;
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (req_ch == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               bytes[0] = req_ch;
               nb       = 3'd1;
            end
         end
      endcase

      // At the end of the text nothing else has been emitted in these two cases.
      if (req_text_end) begin
         if (mode_in == MODE_HEX1) begin
            bytes[0] = held_in;
            nb       = 3'd1;
         end else if (mode_in == MODE_CP) begin
            bytes[3:0] = utf8.bytes;
            nb         = utf8.count;
         end
         mode_in = MODE_NORMAL;
         cp_in   = 32'd0;
      end
   end

   assign push         = accept && (nb != 3'd0);
   assign bundle.bytes = bytes;
   assign bundle.count = nb;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         held_ff <= 8'd0;
         cp_ff   <= 32'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         cp_ff   <= cp_in;
      end
   end

   `SED_ASSERT(a_push_count, clock, reset, push |-> (bundle.count <= 3'(SED_MAX_BYTES)))
   `SED_ASSERT(a_end_normal, clock, reset, (accept && req_text_end) |=> (mode_ff == MODE_NORMAL && cp_ff == 32'd0))

endmodule

FILE: sv/sed_queue.sv
// Short queue of byte bundles between the front and the back.
`include "assert_macros.svh"

module sed_queue #(
   parameter int unsigned DEPTH = sed_pkg::SED_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  sed_pkg::sed_bundle_type       push_bundle,
   input  logic                          pop,
   output sed_pkg::sed_bundle_type       head_bundle,
   output sed_pkg::sed_queue_status_type status
);
   import sed_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   sed_bundle_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_bundle  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   `SED_ASSERT_NEVER(a_push_full, clock, reset, push && status.full)
   `SED_ASSERT_NEVER(a_pop_empty, clock, reset, pop && status.empty)

endmodule

FILE: sv/sed_back.sv
// Back part: sends the bytes of each queued bundle one per cycle while rsp_stall is low.
`include "assert_macros.svh"

module sed_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sed_pkg::sed_bundle_type       head_bundle,
   input  sed_pkg::sed_queue_status_type queue_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_run_end
);
   import sed_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_end_ff, run_end_in;
   logic       load;
   logic       last;

   assign load = !queue_status.empty && (!valid_ff || !rsp_stall);
   assign last = (idx_ff == head_bundle.count - 3'd1);
   assign pop  = load && last;

   always_comb begin
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      run_end_in = run_end_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = !queue_status.empty;
      end
      if (load) begin
         byte_in    = head_bundle.bytes[idx_ff];
         run_end_in = last;
         idx_in     = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      run_end_ff <= run_end_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end  = run_end_ff;

   `SED_ASSERT(a_idx_range, clock, reset, !queue_status.empty |-> (idx_ff < head_bundle.count))

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the string escape decoder top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sed_pkg::*;

   // Decoder modes of the prediction, in the same order as the block's own states.
   typedef enum logic [4:0] {
      MODE_PLAIN      = 5'b00001,
      MODE_ESCAPE     = 5'b00010,
      MODE_HEX_HELD   = 5'b00100,
      MODE_AFTER_U    = 5'b01000,
      MODE_CODE_POINT = 5'b10000
   } decode_mode_type;

   // One decoded byte as it should leave the rsp_ channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } decoded_byte_type;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned RANDOM_IDLING  = 55;
   localparam int unsigned RANDOM_STEADY  = 25;
   localparam int unsigned PRESSURE_COUNT = 20;

   localparam logic [31:0] UTF8_ONE_MAX   = 32'h7F;
   localparam logic [31:0] UTF8_TWO_MAX   = 32'h7FF;
   localparam logic [31:0] UTF8_THREE_MAX = 32'hFFFF;
   localparam logic [31:0] CODE_POINT_MAX = 32'h10FFFF;
   localparam logic [7:0]  LEAD_TWO       = 8'hC0;
   localparam logic [7:0]  LEAD_THREE     = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR      = 8'hF0;
   localparam logic [7:0]  CONTINUATION   = 8'h80;
   localparam logic [7:0]  DIGIT_ZERO     = 8'h30;
   localparam logic [7:0]  UPPER_A        = 8'h41;
   localparam logic [7:0]  LOWER_A        = 8'h61;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch       = 8'h00;
   logic       req_text_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_end;

   // State of the prediction, kept in step with every accepted request.
   decode_mode_type  dec_mode       = MODE_PLAIN;
   logic [7:0]       dec_held       = 8'h00;
   logic [31:0]      dec_code_point = 32'h0;
   logic [7:0]       step_bytes[$];
   decoded_byte_type pending_bytes[$];

   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned requests_sent  = 0;
   bit          sender_idle_on = 1'b0;
   bit          rsp_idle_on    = 1'b0;
   bit          hold_armed     = 1'b0;
   int unsigned hold_left      = 0;
   int unsigned stall_left     = 0;
   int unsigned stall_next     = 0;

   string_escape_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .req_text_end(req_text_end),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_end (rsp_run_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap lengths: half of them zero, most of the rest short, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= DIGIT_ZERO && c <= DIGIT_ZERO + 8'd9) return int'(c - DIGIT_ZERO);
      if (c >= LOWER_A && c <= LOWER_A + 8'd5) return int'(c - LOWER_A) + 10;
      if (c >= UPPER_A && c <= UPPER_A + 8'd5) return int'(c - UPPER_A) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit upper);
      if (nibble < 4'd10) return DIGIT_ZERO + 8'(nibble);
      return (upper ? UPPER_A : LOWER_A) + 8'(nibble) - 8'd10;
   endfunction

   // The block keeps at most five bytes per request; anything beyond is dropped.
   function automatic void emit_byte(input logic [7:0] b);
      if (step_bytes.size() < SED_MAX_BYTES) step_bytes = {step_bytes, b};
   endfunction

   function automatic void emit_utf8(input logic [31:0] cp);
      if (cp <= UTF8_ONE_MAX) begin
         emit_byte(cp[7:0]);
      end else if (cp <= UTF8_TWO_MAX) begin
         emit_byte(LEAD_TWO | 8'(cp[10:6]));
         emit_byte(CONTINUATION | 8'(cp[5:0]));
      end else if (cp <= UTF8_THREE_MAX) begin
         emit_byte(LEAD_THREE | 8'(cp[15:12]));
         emit_byte(CONTINUATION | 8'(cp[11:6]));
         emit_byte(CONTINUATION | 8'(cp[5:0]));
      end else if (cp <= CODE_POINT_MAX) begin
         emit_byte(LEAD_FOUR | 8'(cp[20:18]));
         emit_byte(CONTINUATION | 8'(cp[17:12]));
         emit_byte(CONTINUATION | 8'(cp[11:6]));
         emit_byte(CONTINUATION | 8'(cp[5:0]));
      end
      // Code points above the Unicode range produce nothing at all.
   endfunction

   function automatic void decode_plain(input logic [7:0] c);
      if (c == CH_BACKSLASH) dec_mode = MODE_ESCAPE;
      else emit_byte(c);
   endfunction

   function automatic void decode_escaped(input logic [7:0] c);
      dec_mode = MODE_PLAIN;
      case (c)
         CH_T:         emit_byte(BYTE_TAB);
         CH_N:         emit_byte(BYTE_LF);
         CH_R:         emit_byte(BYTE_CR);
         CH_DQUOTE:    emit_byte(CH_DQUOTE);
         CH_BACKSLASH: emit_byte(CH_BACKSLASH);
         CH_SQUOTE:    emit_byte(CH_SQUOTE);
         CH_U:         dec_mode = MODE_AFTER_U;
         default: begin
            if (hex_value(c) >= 0) begin
               dec_held = c;
               dec_mode = MODE_HEX_HELD;
            end else begin
               emit_byte(c);
            end
         end
      endcase
   endfunction

   // Works out the bytes that one accepted character causes and queues them,
   // marking the last of them as the end of the run.
   function automatic void decode_request(input logic [7:0] c, input logic last);
      int               digit;
      int               high_digit;
      decoded_byte_type entry;
      step_bytes.delete();
      digit = hex_value(c);
      case (dec_mode)
         MODE_ESCAPE: decode_escaped(c);
         MODE_HEX_HELD: begin
            dec_mode = MODE_PLAIN;
            if (digit >= 0) begin
               high_digit = hex_value(dec_held);
               emit_byte(8'((high_digit << 4) | digit));
            end else begin
               emit_byte(dec_held);
               decode_plain(c);
            end
         end
         MODE_AFTER_U: begin
            dec_mode = MODE_PLAIN;
            if (c == CH_LBRACE) begin
               dec_code_point = 32'h0;
               dec_mode = MODE_CODE_POINT;
            end else begin
               decode_plain(c);
            end
         end
         MODE_CODE_POINT: begin
            if (digit >= 0) begin
               // Shifting out the top nibble makes long code points wrap.
               dec_code_point = {dec_code_point[27:0], 4'(digit)};
            end else begin
               emit_utf8(dec_code_point);
               dec_code_point = 32'h0;
               dec_mode = MODE_PLAIN;
               if (c != CH_RBRACE) decode_plain(c);
            end
         end
         default: begin
            dec_mode = MODE_PLAIN;
            decode_plain(c);
         end
      endcase
      if (last) begin
         if (dec_mode == MODE_HEX_HELD) emit_byte(dec_held);
         else if (dec_mode == MODE_CODE_POINT) emit_utf8(dec_code_point);
         dec_mode = MODE_PLAIN;
         dec_code_point = 32'h0;
      end
      foreach (step_bytes[i]) begin
         entry.out_byte = step_bytes[i];
         entry.run_end = (i == step_bytes.size() - 1);
         pending_bytes = {pending_bytes, entry};
      end
   endfunction

   // Offers one character, after an optional gap, and holds it until the
   // block takes it. Valid stays high into the next request when no gap follows.
   task automatic send_request(input logic [7:0] c, input logic last);
      int unsigned gap;
      gap = sender_idle_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_text_end <= last;
      do @(posedge clock); while (req_stall);
      decode_request(c, last);
      requests_sent++;
   endtask

   task automatic send_text(input string s, input bit end_at_last);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], end_at_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] random_hex();
      return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endfunction

   // Sends one random fragment of a literal: mostly well-formed escapes with
   // random content, with some raw bytes and broken escapes mixed in.
   task automatic send_random_token();
      logic [7:0]  chars[$];
      logic [7:0]  c;
      logic [31:0] cp;
      int unsigned kind;
      int unsigned digits;
      int unsigned range_pick;
      bit          end_flag;
      bit          wrap;
      kind = $urandom_range(0, 99);
      end_flag = ($urandom_range(0, 7) == 0);
      if (kind < 25) begin
         chars = {chars, 8'($urandom_range(0, 255))};
      end else if (kind < 40) begin
         chars = {chars, CH_BACKSLASH};
         case ($urandom_range(0, 5))
            0: chars = {chars, CH_T};
            1: chars = {chars, CH_N};
            2: chars = {chars, CH_R};
            3: chars = {chars, CH_DQUOTE};
            4: chars = {chars, CH_BACKSLASH};
            default: chars = {chars, CH_SQUOTE};
         endcase
      end else if (kind < 48) begin
         // An escape the decoder does not know gives the character back.
         do c = random_non_hex();
         while (c == CH_T || c == CH_N || c == CH_R || c == CH_DQUOTE ||
                c == CH_BACKSLASH || c == CH_SQUOTE || c == CH_U);
         chars = {chars, CH_BACKSLASH};
         chars = {chars, c};
      end else if (kind < 62) begin
         chars = {chars, CH_BACKSLASH};
         chars = {chars, random_hex()};
         chars = {chars, random_hex()};
      end else if (kind < 67) begin
         chars = {chars, CH_BACKSLASH};
         chars = {chars, random_hex()};
         chars = {chars, random_non_hex()};
      end else if (kind < 90) begin
         chars = {chars, CH_BACKSLASH};
         chars = {chars, CH_U};
         chars = {chars, CH_LBRACE};
         range_pick = $urandom_range(0, 6);
         wrap = 1'b0;
         case (range_pick)
            0: cp = $urandom_range(0, UTF8_ONE_MAX);
            1: cp = $urandom_range(UTF8_ONE_MAX + 1, UTF8_TWO_MAX);
            2: cp = $urandom_range(UTF8_TWO_MAX + 1, UTF8_THREE_MAX);
            3, 4: cp = $urandom_range(UTF8_THREE_MAX + 1, CODE_POINT_MAX);
            5: cp = $urandom();
            default: wrap = 1'b1;
         endcase
         if (wrap) begin
            // More than eight digits push the early ones out of the top.
            digits = $urandom_range(9, 12);
            repeat (digits) chars = {chars, random_hex()};
         end else begin
            digits = 1;
            while (digits < 8 && (cp >> (4 * digits)) != 0) digits++;
            if (digits < 8 && $urandom_range(0, 3) == 0) digits++;
            for (int k = digits - 1; k >= 0; k--)
               chars = {chars, hex_char(4'(cp >> (4 * k)), 1'($urandom_range(0, 1)))};
         end
         case ($urandom_range(0, 19))
            0, 1, 2: chars = {chars, random_non_hex()};
            3, 4:    end_flag = 1'b1;
            default: chars = {chars, CH_RBRACE};
         endcase
      end else begin
         do c = 8'($urandom_range(0, 255)); while (c == CH_LBRACE);
         chars = {chars, CH_BACKSLASH};
         chars = {chars, CH_U};
         chars = {chars, c};
      end
      foreach (chars[i])
         send_request(chars[i], (end_flag && i == chars.size() - 1) ||
                                ($urandom_range(0, 39) == 0));
   endtask

   // Receiver side. A long hold-off, once armed, keeps rsp_stall high until
   // hold_left has counted down; otherwise short and long random stalls are
   // drawn while receiver idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_armed) begin
            hold_left = HOLD_CYCLES;
            hold_armed = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on) begin
            stall_next = idle_length();
            if (stall_next > 0) stall_left = stall_next - 1;
            rsp_stall <= (stall_next > 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every byte taken from the block is matched against the oldest byte
   // still expected. The expectation is queued just after the edge that
   // accepts its request, ahead of its byte, so there is no race with the sender.
   always @(posedge clock) begin
      decoded_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected response: out_byte 0x%02h run_end %0b",
                   rsp_out_byte, rsp_run_end);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected 0x%02h, actual 0x%02h",
                      want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0b, actual %0b", want.run_end, rsp_run_end);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Raw bytes at both ends of the range pass straight through.
   task automatic test_plain_extremes();
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h7F, 1'b1);
   endtask

   // All six named escapes, plus one the decoder does not know.
   task automatic test_named_escapes();
      send_text("\\t\\n\\r\\\"\\\\\\'\\q", 1'b1);
   endtask

   // A two-digit byte, a pair cut short by a non-hex character, and a single
   // digit left dangling at the end of the text.
   task automatic test_hex_pairs();
      send_text("\\fA\\4z", 1'b0);
      send_text("\\7", 1'b1);
   endtask

   // The largest code point, one past the Unicode range, a code point closed
   // by an ordinary character, one cut off by the end of the text, a \u with
   // no brace, and a \u and a lone backslash at the very end.
   task automatic test_code_points();
      send_text("\\u{10FFFF}\\u{110000}", 1'b0);
      send_text("\\u{e9z\\uq\\u{7FF", 1'b1);
      send_text("\\u", 1'b1);
      send_text("\\", 1'b1);
   endtask

   // Random text with gaps and stalls on both sides.
   task automatic test_random_with_idling();
      int unsigned start;
      sender_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      start = requests_sent;
      while (requests_sent - start < RANDOM_IDLING) send_random_token();
   endtask

   // Random text at full rate in both directions, without any idling.
   task automatic test_random_full_rate();
      int unsigned start;
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      start = requests_sent;
      while (requests_sent - start < RANDOM_STEADY) send_random_token();
   endtask

   // The receiver holds off for a long stretch while characters keep coming,
   // so the bundle queue fills and the block has to stall its input.
   task automatic test_output_hold_off();
      int unsigned start;
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_armed = 1'b1;
      start = requests_sent;
      while (requests_sent - start < PRESSURE_COUNT) send_random_token();
      rsp_idle_on = 1'b1;
      sender_idle_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_plain_extremes();
      test_named_escapes();
      test_hex_pairs();
      test_code_points();
      test_random_with_idling();
      test_random_full_rate();
      test_output_hold_off();
      test_random_with_idling();
      req_valid <= 1'b0;

      // Let the queue drain, then give any stray byte a chance to show up.
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
